@@ sv/keyframe_linear_interpolator_core_assert.svh @@
// ----------------------------------------------------------------------------
// Keyframe interpolator assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication
`define KLI_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/kli_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyframe interpolator package
// Field widths, stream packing, opcodes and sequencer state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package kli_pkg;

	localparam int KC_W      = 5;
	localparam int IDX_W     = 4;
	localparam int TIME_W    = 32;
	localparam int VAL_W     = 32;
	localparam int SEG_W     = 4;
	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 40;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_FIRST = 8'b0000_0010,
		ST_CHK   = 8'b0000_0100,
		ST_DIV   = 8'b0000_1000,
		ST_MUL1  = 8'b0001_0000,
		ST_MUL2  = 8'b0010_0000,
		ST_RES   = 8'b0100_0000,
		ST_END   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] t;
		logic [VAL_W-1:0]  v;
	} key_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [SEG_W-1:0] seg;
	} result_t;

endpackage

`default_nettype wire

@@ sv/kli_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/keyframe_linear_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// Keyframe linear interpolator
// Keyframe table in RAM, segment walk with serial divide and shared multiplier.
// ----------------------------------------------------------------------------
// A load transfer (tuser 0) writes one keyframe slot (key_index below
// MAX_KEYS). A query transfer (tuser 1) walks the segments of the first
// key_count keyframes (at most MAX_KEYS), one RAM read per cycle while no
// segment matches. For each segment containing the query time it runs a
// one-bit-per-cycle divide for the blend factor, two passes through one
// multiplier and one rounding add, or skips the divide when that segment's two times are equal.
// Results are held one deep so the final one can carry tlast; output stalls
// hold the walk. A query with fewer than two keys gives no result.
// Write key_count only while no query is in flight.
`default_nettype none

`include "keyframe_linear_interpolator_core_assert.svh"

module keyframe_linear_interpolator_core
	import kli_pkg::*;
#(
	parameter int MAX_KEYS      = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [KC_W-1:0]      cfg_data,       // key_count
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,   // key_index, key_time, key_value, query_time
	input  logic                 s_axis_tuser,   // opcode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,   // tween_value, segment_index
	output logic                 m_axis_tlast
);

	localparam int AW      = $clog2(MAX_KEYS);
	localparam int FB      = FRACTION_BITS;
	localparam int CNT_W   = $clog2(FB + 1);
	localparam int IW      = KC_W + 1;
	localparam int PROD_W  = TIME_W + FB + 1;
	localparam int SUM_W   = PROD_W + 1;
	localparam logic [FB:0]      ONE_FIX = {1'b1, {FB{1'b0}}};
	localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << (FB - 1);

	state_t                state_q;
	logic [KC_W-1:0]       key_count_q;
	logic [KC_W-1:0]       n_q;
	logic [KC_W-1:0]       idx_q;
	logic [TIME_W-1:0]     q_q;
	key_t                  prev_q;
	key_t                  cur_q;
	logic [TIME_W:0]       rem_q;
	logic [TIME_W-1:0]     d_q;
	logic [FB:0]           f_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PROD_W-1:0]     prod_q;
	logic [PROD_W-1:0]     acc_q;
	result_t               pend_q;
	logic                  pend_v_q;
	result_t               out_q;
	logic                  out_last_q;
	logic                  out_v_q;

	logic                  in_xfer;
	logic [IDX_W-1:0]      in_index;
	logic [TIME_W-1:0]     in_time;
	logic [VAL_W-1:0]      in_value;
	logic [TIME_W-1:0]     in_query;
	logic [KC_W-1:0]       n_sel;
	logic                  n_ok;
	logic                  slot_ok;
	logic                  ram_we;
	logic                  ram_re;
	logic [IW-1:0]         rd_idx;
	logic [$bits(key_t)-1:0] ram_rdata;
	key_t                  rd_key;
	logic                  match;
	logic                  at_end;
	logic                  out_free;
	logic                  res_go;
	logic                  push;
	logic                  div_ge;
	logic [TIME_W:0]       rem_nx;
	logic [TIME_W-1:0]     mul_a;
	logic [FB:0]           mul_b;
	logic [PROD_W-1:0]     mul_p;
	logic [SUM_W-1:0]      sum;
	logic [VAL_W-1:0]      res_value;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign in_index = s_axis_tdata[3:0];
	assign in_time  = s_axis_tdata[35:4];
	assign in_value = s_axis_tdata[67:36];
	assign in_query = s_axis_tdata[99:68];

	assign n_sel   = (int'(key_count_q) > MAX_KEYS) ? KC_W'(MAX_KEYS) : key_count_q;
	assign n_ok    = n_sel >= KC_W'(2);
	assign slot_ok = int'(in_index) < MAX_KEYS;
	assign ram_we  = in_xfer && (s_axis_tuser == OP_LOAD) && slot_ok;

	assign rd_key   = key_t'(ram_rdata);
	assign match    = (q_q >= prev_q.t) && (q_q <= rd_key.t);
	assign at_end   = (IW'(idx_q) + IW'(2)) == IW'(n_q);
	assign out_free = !out_v_q || m_axis_tready;
	assign res_go   = !pend_v_q || out_free;
	assign push     = pend_v_q && out_free && ((state_q == ST_RES) || (state_q == ST_END));

	always_comb begin
		ram_re = 1'b0;
		rd_idx = '0;
		case (state_q)
			ST_IDLE: begin
				ram_re = in_xfer && (s_axis_tuser == OP_QUERY) && n_ok;
			end
			ST_FIRST: begin
				ram_re = 1'b1;
				rd_idx = IW'(1);
			end
			ST_CHK: begin
				ram_re = !match && !at_end;
				rd_idx = IW'(idx_q) + IW'(2);
			end
			ST_RES: begin
				ram_re = res_go && !at_end;
				rd_idx = IW'(idx_q) + IW'(2);
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	kli_ram #(
		.WIDTH ($bits(key_t)),
		.DEPTH (MAX_KEYS)
	) u_keys (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_index)),
		.wdata ({in_time, in_value}),
		.re    (ram_re),
		.raddr (AW'(rd_idx)),
		.rdata (ram_rdata)
	);

	// restoring divide step, remainder stays below twice the divisor
	assign div_ge = rem_q >= {1'b0, d_q};
	assign rem_nx = div_ge ? (rem_q - {1'b0, d_q}) : rem_q;

	// offset-binary operands, weights 1.0-f then f
	assign mul_a = (state_q == ST_MUL1) ? {~prev_q.v[VAL_W-1], prev_q.v[VAL_W-2:0]}
	                                    : {~cur_q.v[VAL_W-1], cur_q.v[VAL_W-2:0]};
	assign mul_b = (state_q == ST_MUL1) ? (ONE_FIX - f_q) : f_q;
	assign mul_p = {{(FB + 1){1'b0}}, mul_a} * {{TIME_W{1'b0}}, mul_b};

	assign sum       = {1'b0, acc_q} + {1'b0, prod_q} + HALF;
	assign res_value = {~sum[FB+VAL_W-1], sum[FB+VAL_W-2:FB]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= '0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				key_count_q <= cfg_data;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && (s_axis_tuser == OP_QUERY) && n_ok) begin
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (match) begin
						state_q <= (rd_key.t == prev_q.t) ? ST_MUL1 : ST_DIV;
					end else if (at_end) begin
						state_q <= ST_END;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (res_go) begin
						pend_v_q <= 1'b1;
						state_q  <= at_end ? ST_END : ST_CHK;
					end
				end
				ST_END: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					q_q   <= in_query;
					n_q   <= n_sel;
					idx_q <= '0;
				end
			end
			ST_FIRST: begin
				prev_q <= rd_key;
			end
			ST_CHK: begin
				cur_q <= rd_key;
				rem_q <= {1'b0, q_q - prev_q.t};
				d_q   <= rd_key.t - prev_q.t;
				f_q   <= '0;
				cnt_q <= CNT_W'(FB);
				if (!match) begin
					prev_q <= rd_key;
					idx_q  <= idx_q + KC_W'(1);
				end
			end
			ST_DIV: begin
				f_q   <= {f_q[FB-1:0], div_ge};
				rem_q <= {rem_nx[TIME_W-1:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_MUL1: begin
				prod_q <= mul_p;
			end
			ST_MUL2: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			ST_RES: begin
				if (res_go) begin
					pend_q <= '{value: res_value, seg: idx_q[SEG_W-1:0]};
					prev_q <= cur_q;
					idx_q  <= idx_q + KC_W'(1);
				end
			end
			default: begin
			end
		endcase
		if (push) begin
			out_q      <= pend_q;
			out_last_q <= (state_q == ST_END);
		end
	end

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {{(M_TDATA_W - VAL_W - SEG_W){1'b0}}, out_q.seg, out_q.value};
	assign m_axis_tlast  = out_last_q;

	`KLI_ASSERT_HOLDS(a_idle_no_pend, state_q == ST_IDLE, !pend_v_q, "result stranded in idle")
	`KLI_ASSERT_HOLDS(a_factor_range, state_q == ST_MUL1, f_q <= ONE_FIX, "blend factor above one")
	`KLI_ASSERT_NEXT(a_last_ends, push && (state_q == ST_END), state_q == ST_IDLE, "walk past last")

endmodule

`default_nettype wire
